// ----- src/assert_macros.svh -----
// Assertion macros shared by the header swapper RTL.
// Included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TUSW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tusw: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define TUSW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tusw: next-cycle check failed");

`endif

// ----- src/tusw_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants for the TCP / UDP-form header swapper.
// No dependencies.
package tusw_pkg;

    localparam int DATA_W = 64;
    localparam int BV_W   = 4;
    localparam int RAM_W  = DATA_W + BV_W;

    localparam logic [15:0] ET_IPV4   = 16'h0800;
    localparam logic [15:0] ET_IPV6   = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int ETH_HDR   = 14;
    localparam int ET_OFFS   = 12;
    localparam int IPV4_MIN  = 20;
    localparam int IPV6_HDR  = 40;
    localparam int L4_BYTES  = 20;
    localparam int L3_SLOTS  = 9;
    localparam int L3_FIRST  = 2;
    localparam int L4_FIRST  = L3_FIRST + L3_SLOTS;
    localparam int SLOT_NUM  = L4_FIRST + L4_BYTES;

    localparam logic [4:0] LOAD_LAST     = 5'(SLOT_NUM - 1);
    localparam logic [4:0] ST_PROTO      = 5'd20;
    localparam logic [4:0] ST_CK_HI      = 5'd21;
    localparam logic [4:0] ST_CK_LO      = 5'd22;
    localparam logic [4:0] ST_LAST_V4    = ST_CK_LO;
    localparam logic [4:0] ST_LAST_V6    = ST_PROTO;
    localparam logic [3:0] MATH_LAST     = 4'd13;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_T2U  = 2'd1,
        KIND_U2T  = 2'd2
    } t_kind;

    typedef struct packed {
        logic       wr_in;
        logic       first;
        logic       ld_cap;
        logic       st_phase;
        logic       st_wr;
        logic       decide;
        logic       math;
        logic [3:0] math_step;
        logic [4:0] step;
        logic       rd_flush;
        logic       fl_ld;
        logic       fl_last;
        logic       pass_ld;
    } t_cmd;

    typedef struct packed {
        t_kind dec_kind;
        logic  v4;
        logic  out_free;
    } t_sts;

    // byte offsets from the L3 base of the fields kept in L3 slots
    function automatic logic [3:0] l3_off(input logic [3:0] idx);
        logic [3:0] r;
        unique case (idx)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd3;
            4'd3:    r = 4'd4;
            4'd4:    r = 4'd5;
            4'd5:    r = 4'd6;
            4'd6:    r = 4'd9;
            4'd7:    r = 4'd10;
            4'd8:    r = 4'd11;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/tusw_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the header swapper: packet words with valid / ready.
// No dependencies.
interface tusw_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] packet_word;
    logic [3:0]  bytes_valid;
    logic        last_word;
    logic [15:0] l3_protocol;
    logic        segmented;

    modport source (output valid, packet_word, bytes_valid, last_word, l3_protocol,
                    segmented, input ready);
    modport sink (input valid, packet_word, bytes_valid, last_word, l3_protocol,
                  segmented, output ready);
endinterface

// ----- src/tusw_out_if.sv -----
`timescale 1ns / 1ps
// Output channel of the header swapper: rewritten words with valid / ready.
// No dependencies.
interface tusw_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_word;
    logic [3:0]  out_bytes_valid;
    logic        out_last;
    logic [1:0]  rewrite_kind;
    logic        verdict;

    modport source (output valid, out_word, out_bytes_valid, out_last, rewrite_kind,
                    verdict, input ready);
    modport sink (input valid, out_word, out_bytes_valid, out_last, rewrite_kind,
                  verdict, output ready);
endinterface

// ----- src/tcp_udp_header_swapper_unit.sv -----
// A packet's head (up to HEAD_WORDS words) is held until its last word or a full buffer,
// then parsed by 31 byte loads and one decision; a rewrite adds checksum steps and a
// RAM read and write per stored byte. Head words then leave one by one through the single
// RAM read port, held while the output stalls; later words of the same packet pass at one
// per cycle while the output accepts. Collection takes one word per cycle. Reset is
// synchronous, active low, clears control state; buffer contents stay undefined.
`timescale 1ns / 1ps
// Top level of the TCP / UDP-form header swapper.
// Depends on tusw_pkg, tusw_in_if, tusw_out_if, tusw_ctrl, tusw_datapath.
module tcp_udp_header_swapper_unit
    import tusw_pkg::*;
#(
    parameter int HEAD_WORDS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tusw_in_if.sink    i_pkt,
    tusw_out_if.source o_res
);
    localparam int IW = (HEAD_WORDS > 1) ? $clog2(HEAD_WORDS) : 1;

    t_cmd          cmd;
    t_sts          sts;
    logic [IW-1:0] idx;
    logic          in_ready;

    assign i_pkt.ready = in_ready;

    tusw_ctrl #(.HEAD_WORDS(HEAD_WORDS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pkt.valid),
        .i_in_last  (i_pkt.last_word),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .o_idx      (idx),
        .i_sts      (sts)
    );

    tusw_datapath #(.HEAD_WORDS(HEAD_WORDS)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_idx         (idx),
        .i_packet_word (i_pkt.packet_word),
        .i_bytes_valid (i_pkt.bytes_valid),
        .i_last_word   (i_pkt.last_word),
        .i_l3_protocol (i_pkt.l3_protocol),
        .i_segmented   (i_pkt.segmented),
        .o_sts         (sts),
        .o_out         (o_res)
    );
endmodule

// ----- src/tusw_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tusw_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/tusw_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: head buffer RAM, parse slots, decision, checksum ALU, output register.
// Depends on tusw_pkg, tusw_ram, tusw_out_if.
module tusw_datapath
    import tusw_pkg::*;
#(
    parameter int HEAD_WORDS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [((HEAD_WORDS > 1) ? $clog2(HEAD_WORDS) : 1)-1:0] i_idx,
    input  logic [63:0]            i_packet_word,
    input  logic [3:0]             i_bytes_valid,
    input  logic                   i_last_word,
    input  logic [15:0]            i_l3_protocol,
    input  logic                   i_segmented,
    output t_sts                   o_sts,
    tusw_out_if.source             o_out
);
    localparam int IW  = (HEAD_WORDS > 1) ? $clog2(HEAD_WORDS) : 1;
    localparam int AW0 = $clog2(HEAD_WORDS * 8 + 1);
    localparam int AW  = (AW0 > 8) ? AW0 : 8;

    logic [AW-1:0]   r_avail;
    logic            r_stop;
    logic [15:0]     r_held_proto;
    logic            r_held_seg;
    logic [7:0]      r_slot [SLOT_NUM];
    t_kind           r_kind;
    logic [31:0]     r_acc;
    logic [15:0]     r_len;
    logic [15:0]     r_ipck;
    logic [15:0]     r_ck;
    logic            r_out_valid;
    logic [63:0]     r_out_word;
    logic [3:0]      r_out_bv;
    logic            r_out_last;
    t_kind           r_out_kind;

    logic [3:0]      bv_c;
    logic [15:0]     et;
    logic            eth;
    logic [AW-1:0]   base;
    logic [15:0]     eff_et;
    logic            v4, v6;
    logic [3:0]      ihl;
    logic [AW-1:0]   ihl4;
    logic [AW-1:0]   t;
    logic [7:0]      l3proto;
    logic [3:0]      doff;
    logic            ok3, ok4, tcp_ok, udp_ok;
    t_kind           dec;
    logic [AW-1:0]   ld_addr, st_addr, baddr;
    logic [IW-1:0]   word_idx;
    logic [2:0]      lane;
    logic [RAM_W-1:0] rdata;
    logic [7:0]      rd_byte;
    logic [7:0]      st_byte;
    logic [63:0]     mod_word;
    logic            ram_we;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    logic [RAM_W-1:0] ram_wdata;
    logic            is_tcp;
    logic [15:0]     n_len;
    logic [31:0]     n_acc;
    logic [16:0]     sum16;
    logic [32:0]     sum32;
    logic [15:0]     op16;
    logic [31:0]     op32;
    logic            out_free;

    tusw_ram #(.WIDTH(RAM_W), .DEPTH(HEAD_WORDS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    assign bv_c = (i_bytes_valid > 4'd8) ? 4'd8 : i_bytes_valid;

    // parse view of the loaded slots
    always_comb begin
        et      = {r_slot[0], r_slot[1]};
        eth     = (r_avail >= AW'(ETH_HDR)) && (et == ET_IPV4 || et == ET_IPV6);
        base    = eth ? AW'(ETH_HDR) : '0;
        eff_et  = eth ? et : r_held_proto;
        v4      = (eff_et == ET_IPV4);
        v6      = (eff_et == ET_IPV6);
        ihl     = r_slot[L3_FIRST][3:0];
        ihl4    = AW'({ihl, 2'b00});
        t       = v4 ? (base + ihl4) : (base + AW'(IPV6_HDR));
        l3proto = v4 ? r_slot[L3_FIRST + 6] : r_slot[L3_FIRST + 5];
        doff    = r_slot[L4_FIRST + 12][7:4];
        if (v4) begin
            ok3 = (base + AW'(IPV4_MIN) <= r_avail) && (ihl >= 4'd5) &&
                  (base + ihl4 <= r_avail);
        end else if (v6) begin
            ok3 = (base + AW'(IPV6_HDR) <= r_avail);
        end else begin
            ok3 = 1'b0;
        end
        ok4    = (t + AW'(L4_BYTES) <= r_avail);
        tcp_ok = (doff >= 4'd5) && (t + AW'({doff, 2'b00}) <= r_avail) &&
                 !r_slot[L4_FIRST + 13][5] && !r_held_seg;
        udp_ok = ({r_slot[L4_FIRST + 4], r_slot[L4_FIRST + 5]} >= 16'd8) && !r_held_seg;
        dec    = KIND_NONE;
        if (ok3 && ok4) begin
            if (l3proto == PROTO_TCP && tcp_ok) begin
                dec = KIND_T2U;
            end else if (l3proto == PROTO_UDP && udp_ok) begin
                dec = KIND_U2T;
            end
        end
    end

    // byte addresses of the load and store sequences
    always_comb begin
        if (i_cmd.step < 5'(L3_FIRST)) begin
            ld_addr = AW'(ET_OFFS) + AW'(i_cmd.step);
        end else if (i_cmd.step < 5'(L4_FIRST)) begin
            ld_addr = base + AW'(l3_off(4'(i_cmd.step - 5'(L3_FIRST))));
        end else begin
            ld_addr = t + AW'(i_cmd.step - 5'(L4_FIRST));
        end
        if (i_cmd.step < ST_PROTO) begin
            st_addr = t + AW'(i_cmd.step);
        end else if (i_cmd.step == ST_PROTO) begin
            st_addr = base + (v4 ? AW'(9) : AW'(6));
        end else if (i_cmd.step == ST_CK_HI) begin
            st_addr = base + AW'(10);
        end else begin
            st_addr = base + AW'(11);
        end
        baddr    = i_cmd.st_phase ? st_addr : ld_addr;
        word_idx = baddr[IW+2:3];
        lane     = baddr[2:0];
    end

    assign is_tcp  = (r_kind == KIND_T2U);
    assign rd_byte = rdata[63 - 8 * lane -: 8];

    // rewritten L4 header byte
    function automatic logic [7:0] l4_new(input logic [4:0] i, input logic tcp,
                                          input logic [7:0] c [SLOT_NUM],
                                          input logic [15:0] len, input logic [15:0] ck);
        logic [7:0] r;
        r = 8'h00;
        if (i < 5'd4) begin
            r = c[L4_FIRST + i];
        end else if (tcp) begin
            if (i == 5'd4)       r = len[15:8];
            else if (i == 5'd5)  r = len[7:0];
            else if (i == 5'd6)  r = ck[15:8];
            else if (i == 5'd7)  r = ck[7:0];
            else if (i < 5'd12)  r = c[L4_FIRST + 4 + i];
            else if (i < 5'd16)  r = c[L4_FIRST + i - 8];
            else                 r = c[L4_FIRST + i - 8];
        end else begin
            if (i < 5'd8)        r = c[L4_FIRST + 8 + i];
            else if (i < 5'd12)  r = c[L4_FIRST + 8 + i];
            else if (i < 5'd16)  r = c[L4_FIRST + i - 4];
            else if (i == 5'd16) r = ck[15:8];
            else if (i == 5'd17) r = ck[7:0];
            else                 r = 8'h00;
        end
        return r;
    endfunction

    always_comb begin
        if (i_cmd.step < ST_PROTO) begin
            st_byte = l4_new(i_cmd.step, is_tcp, r_slot, r_len, r_ck);
        end else if (i_cmd.step == ST_PROTO) begin
            st_byte = is_tcp ? PROTO_UDP : PROTO_TCP;
        end else if (i_cmd.step == ST_CK_HI) begin
            st_byte = r_ipck[15:8];
        end else begin
            st_byte = r_ipck[7:0];
        end
        mod_word = rdata[63:0];
        for (int k = 0; k < 8; k++) begin
            if (lane == 3'(k)) begin
                mod_word[63 - 8 * k -: 8] = st_byte;
            end
        end
    end

    assign ram_we    = i_cmd.wr_in | i_cmd.st_wr;
    assign ram_waddr = i_cmd.wr_in ? i_idx : word_idx;
    assign ram_wdata = i_cmd.wr_in ? {bv_c, i_packet_word} : {rdata[RAM_W-1:DATA_W], mod_word};
    assign ram_raddr = i_cmd.rd_flush ? i_idx : word_idx;

    // checksum ALU: one ones' complement load, add, fold or truncate per step
    always_comb begin
        if (is_tcp) begin
            n_len = v4 ? ({r_slot[L3_FIRST + 1], r_slot[L3_FIRST + 2]} - {10'd0, ihl, 2'b00})
                       : {r_slot[L3_FIRST + 3], r_slot[L3_FIRST + 4]};
        end else begin
            n_len = {r_slot[L4_FIRST + 4], r_slot[L4_FIRST + 5]};
        end
        op16 = '0;
        op32 = '0;
        case (i_cmd.math_step)
            4'd1:    op16 = is_tcp ? ~16'(PROTO_TCP) : ~16'(PROTO_UDP);
            4'd2:    op16 = is_tcp ? 16'(PROTO_UDP) : 16'(PROTO_TCP);
            4'd4:    op32 = is_tcp ? ~32'(PROTO_TCP) : ~32'(PROTO_UDP);
            4'd5:    op32 = is_tcp ? 32'(PROTO_UDP) : 32'(PROTO_TCP);
            4'd9:    op32 = is_tcp ? 32'hFFFF_FFFF : ~{16'd0, r_len};
            4'd10:   op32 = is_tcp ? {16'd0, r_len} : 32'd0;
            default: op32 = '0;
        endcase
        sum16 = {1'b0, r_acc[15:0]} + {1'b0, op16};
        sum32 = {1'b0, r_acc} + {1'b0, op32};
        case (i_cmd.math_step)
            4'd0:    n_acc = {16'd0, ~{r_slot[L3_FIRST + 7], r_slot[L3_FIRST + 8]}};
            4'd1, 4'd2: n_acc = {16'd0, sum16[15:0] + 16'(sum16[16])};
            4'd3:    n_acc = is_tcp ? {16'd0, ~{r_slot[L4_FIRST + 16], r_slot[L4_FIRST + 17]}}
                                    : {16'd0, ~{r_slot[L4_FIRST + 6], r_slot[L4_FIRST + 7]}};
            4'd4, 4'd5, 4'd9, 4'd10: n_acc = sum32[31:0] + 32'(sum32[32]);
            4'd6, 4'd7, 4'd11, 4'd12: n_acc = 32'(r_acc[15:0]) + 32'(r_acc[31:16]);
            4'd8:    n_acc = {16'd0, r_acc[15:0]};
            default: n_acc = r_acc;
        endcase
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail      <= '0;
            r_stop       <= 1'b0;
            r_held_proto <= '0;
            r_held_seg   <= 1'b0;
            r_kind       <= KIND_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.wr_in) begin
                if (i_cmd.first) begin
                    r_avail      <= AW'(bv_c);
                    r_stop       <= (bv_c < 4'd8);
                    r_held_proto <= i_l3_protocol;
                    r_held_seg   <= i_segmented;
                end else if (!r_stop) begin
                    r_avail <= r_avail + AW'(bv_c);
                    r_stop  <= (bv_c < 4'd8);
                end
            end
            if (i_cmd.decide) begin
                r_kind <= dec;
            end
            if (i_cmd.fl_ld || i_cmd.pass_ld) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_cap) begin
            r_slot[i_cmd.step] <= rd_byte;
        end
        if (i_cmd.math) begin
            r_acc <= n_acc;
            if (i_cmd.math_step == 4'd0) begin
                r_len <= n_len;
            end
            if (i_cmd.math_step == 4'd3) begin
                r_ipck <= ~r_acc[15:0];
            end
            if (i_cmd.math_step == MATH_LAST) begin
                r_ck <= ~r_acc[15:0];
            end
        end
        if (i_cmd.fl_ld) begin
            r_out_word <= rdata[63:0];
            r_out_bv   <= rdata[RAM_W-1:DATA_W];
            r_out_last <= i_cmd.fl_last;
            r_out_kind <= r_kind;
        end else if (i_cmd.pass_ld) begin
            r_out_word <= i_packet_word;
            r_out_bv   <= bv_c;
            r_out_last <= i_last_word;
            r_out_kind <= r_kind;
        end
    end

    assign o_sts.dec_kind      = dec;
    assign o_sts.v4            = v4;
    assign o_sts.out_free      = out_free;
    assign o_out.valid           = r_out_valid;
    assign o_out.out_word        = r_out_word;
    assign o_out.out_bytes_valid = r_out_bv;
    assign o_out.out_last        = r_out_last;
    assign o_out.rewrite_kind    = r_out_kind;
    assign o_out.verdict         = (r_out_kind == KIND_T2U);
endmodule

// ----- src/tusw_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: collect, load, decide, checksum, store, flush and pass sequencing.
// Depends on tusw_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tusw_ctrl
    import tusw_pkg::*;
#(
    parameter int HEAD_WORDS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    output t_cmd o_cmd,
    output logic [((HEAD_WORDS > 1) ? $clog2(HEAD_WORDS) : 1)-1:0] o_idx,
    input  t_sts i_sts
);
    localparam int IW  = (HEAD_WORDS > 1) ? $clog2(HEAD_WORDS) : 1;
    localparam int WCW = $clog2(HEAD_WORDS + 1);

    typedef enum logic [3:0] {
        S_COLLECT, S_LD_RD, S_LD_CAP, S_DECIDE, S_MATH,
        S_ST_RD, S_ST_WR, S_FL_RD, S_FL_CAP, S_PASS
    } t_state;

    t_state         r_state;
    logic [WCW-1:0] r_wc;
    logic [WCW-1:0] r_fn;
    logic [WCW-1:0] r_fi;
    logic [4:0]     r_step;
    logic [3:0]     r_ms;
    logic           r_last_in;
    logic           acc;
    logic [WCW-1:0] wc_inc;
    logic           fl_end;

    always_comb begin
        unique case (r_state)
            S_COLLECT: o_in_ready = 1'b1;
            S_PASS:    o_in_ready = i_sts.out_free;
            default:   o_in_ready = 1'b0;
        endcase
    end

    assign acc    = i_in_valid && o_in_ready;
    assign wc_inc = r_wc + WCW'(1);
    assign fl_end = (r_fi == r_fn - WCW'(1));

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_in     = (r_state == S_COLLECT) && acc;
        o_cmd.first     = (r_wc == '0);
        o_cmd.ld_cap    = (r_state == S_LD_CAP);
        o_cmd.st_phase  = (r_state == S_ST_RD) || (r_state == S_ST_WR);
        o_cmd.st_wr     = (r_state == S_ST_WR);
        o_cmd.decide    = (r_state == S_DECIDE);
        o_cmd.math      = (r_state == S_MATH);
        o_cmd.math_step = r_ms;
        o_cmd.step      = r_step;
        o_cmd.rd_flush  = (r_state == S_FL_RD) || (r_state == S_FL_CAP);
        o_cmd.fl_ld     = (r_state == S_FL_CAP) && i_sts.out_free;
        o_cmd.fl_last   = r_last_in && fl_end;
        o_cmd.pass_ld   = (r_state == S_PASS) && acc;
        o_idx           = (r_state == S_COLLECT) ? r_wc[IW-1:0] : r_fi[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_COLLECT;
            r_wc      <= '0;
            r_fn      <= '0;
            r_fi      <= '0;
            r_step    <= '0;
            r_ms      <= '0;
            r_last_in <= 1'b0;
        end else begin
            unique case (r_state)
                S_COLLECT: begin
                    if (acc) begin
                        if (i_in_last || wc_inc == WCW'(HEAD_WORDS)) begin
                            r_fn      <= wc_inc;
                            r_last_in <= i_in_last;
                            r_wc      <= '0;
                            r_step    <= '0;
                            r_state   <= S_LD_RD;
                        end else begin
                            r_wc <= wc_inc;
                        end
                    end
                end
                S_LD_RD: r_state <= S_LD_CAP;
                S_LD_CAP: begin
                    if (r_step == LOAD_LAST) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_step  <= r_step + 5'd1;
                        r_state <= S_LD_RD;
                    end
                end
                S_DECIDE: begin
                    r_fi   <= '0;
                    r_ms   <= '0;
                    r_step <= '0;
                    r_state <= (i_sts.dec_kind == KIND_NONE) ? S_FL_RD : S_MATH;
                end
                S_MATH: begin
                    if (r_ms == MATH_LAST) begin
                        r_state <= S_ST_RD;
                    end else begin
                        r_ms <= r_ms + 4'd1;
                    end
                end
                S_ST_RD: r_state <= S_ST_WR;
                S_ST_WR: begin
                    if (r_step == (i_sts.v4 ? ST_LAST_V4 : ST_LAST_V6)) begin
                        r_state <= S_FL_RD;
                    end else begin
                        r_step  <= r_step + 5'd1;
                        r_state <= S_ST_RD;
                    end
                end
                S_FL_RD: r_state <= S_FL_CAP;
                S_FL_CAP: begin
                    if (i_sts.out_free) begin
                        if (fl_end) begin
                            r_state <= r_last_in ? S_COLLECT : S_PASS;
                        end else begin
                            r_fi    <= r_fi + WCW'(1);
                            r_state <= S_FL_RD;
                        end
                    end
                end
                S_PASS: begin
                    if (acc && i_in_last) begin
                        r_state <= S_COLLECT;
                    end
                end
                default: r_state <= S_COLLECT;
            endcase
        end
    end

    `TUSW_ASSERT_IMP(a_store_needs_rewrite, i_clk, i_rst_n, r_state == S_ST_WR, i_sts.dec_kind != KIND_NONE)
    `TUSW_ASSERT_IMP(a_flush_in_range, i_clk, i_rst_n, r_state == S_FL_RD || r_state == S_FL_CAP, r_fi < r_fn)
    `TUSW_ASSERT_IMP(a_collect_bound, i_clk, i_rst_n, r_state == S_COLLECT, r_wc < WCW'(HEAD_WORDS))
    `TUSW_ASSERT_NXT(a_open_packet_passes, i_clk, i_rst_n, r_state == S_FL_CAP && i_sts.out_free && fl_end && !r_last_in, r_state == S_PASS)
endmodule

// ----- bench/tusw_checker.sv -----
`timescale 1ns / 1ps
// Checker for the header swapper: watches both channels, predicts the
// output words of every packet and compares them. Depends on tusw_pkg and the channel interfaces.
module tusw_checker
    import tusw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    tusw_in_if    i_pkt,
    tusw_out_if   i_res,
    output int    o_fail_cnt,
    output int    o_pending,
    output int    o_t2u_words,
    output int    o_u2t_words
);

    localparam int NWORDS = 16;

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_PASS,
        PH_T2U,
        PH_U2T
    } t_phase;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  bv;
        logic        last;
        t_kind       kind;
        logic        verdict;
    } t_out_word;

    t_out_word   expected_q[$];
    logic [63:0] head_w[NWORDS];
    logic [3:0]  head_bv[NWORDS];
    int          head_cnt;
    t_phase      phase;
    logic [15:0] tag_held;
    logic        seg_held;

    function automatic logic [7:0] rd8(int p);
        if (p >= NWORDS * 8) return 8'h00;
        return head_w[p >> 3][(7 - (p & 7)) * 8 +: 8];
    endfunction

    function automatic void wr8(int p, logic [7:0] v);
        if (p < NWORDS * 8) head_w[p >> 3][(7 - (p & 7)) * 8 +: 8] = v;
    endfunction

    function automatic logic [15:0] rd16(int p);
        return {rd8(p), rd8(p + 1)};
    endfunction

    function automatic void wr16(int p, logic [15:0] v);
        wr8(p, v[15:8]);
        wr8(p + 1, v[7:0]);
    endfunction

    function automatic logic [15:0] oc_add16(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = a + b;
        return s[15:0] + s[16];
    endfunction

    // IPv4 header checksum: 16-bit replace
    function automatic logic [15:0] ip_patch(logic [15:0] ck, logic [15:0] from,
                                             logic [15:0] to);
        return ~oc_add16(oc_add16(~ck, ~from), to);
    endfunction

    function automatic logic [31:0] oc_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = a + b;
        return s[31:0] + s[32];
    endfunction

    // L4 checksum: 32-bit accumulate, folded twice
    function automatic logic [15:0] l4_patch(logic [15:0] ck, logic [31:0] from,
                                             logic [31:0] to);
        logic [31:0] s;
        s = {16'h0, ~ck};
        s = oc_add32(s, ~from);
        s = oc_add32(s, to);
        s = s[15:0] + s[31:16];
        s = s[15:0] + s[31:16];
        return ~s[15:0];
    endfunction

    function automatic t_phase parse_head();
        int          avail, base, t, ihl, doff;
        logic        v4;
        logic [16:0] et;
        logic [7:0]  proto;
        logic [7:0]  c[20];
        logic [15:0] len, ck;
        avail = 0;
        v4 = 0;
        ihl = 0;
        for (int i = 0; i < head_cnt; i++) begin
            avail += head_bv[i];
            if (head_bv[i] < 8) break;
        end
        et = avail >= 14 ? {1'b0, rd16(12)} : 17'h10000;
        if (et == {1'b0, ET_IPV4} || et == {1'b0, ET_IPV6}) begin
            base = 14;
        end else begin
            base = 0;
            et = {1'b0, tag_held};
        end
        if (et == {1'b0, ET_IPV4}) begin
            v4 = 1;
            if (base + 20 > avail) return PH_PASS;
            ihl = rd8(base) & 15;
            if (ihl < 5 || base + ihl * 4 > avail) return PH_PASS;
            t = base + ihl * 4;
            proto = rd8(base + 9);
        end else if (et == {1'b0, ET_IPV6}) begin
            if (base + 40 > avail) return PH_PASS;
            t = base + 40;
            proto = rd8(base + 6);
        end else begin
            return PH_PASS;
        end
        if (proto == PROTO_TCP) begin
            if (t + 20 > avail) return PH_PASS;
            doff = rd8(t + 12) >> 4;
            if (doff < 5 || t + doff * 4 > avail) return PH_PASS;
            if (rd8(t + 13) & 8'h20) return PH_PASS;
            if (seg_held) return PH_PASS;
            len = v4 ? rd16(base + 2) - 16'(ihl * 4) : rd16(base + 4);
            for (int i = 0; i < 20; i++) c[i] = rd8(t + i);
            wr16(t + 4, len);
            wr8(t + 6, c[16]);
            wr8(t + 7, c[17]);
            for (int i = 0; i < 4; i++) begin
                wr8(t + 8 + i, c[12 + i]);
                wr8(t + 12 + i, c[4 + i]);
                wr8(t + 16 + i, c[8 + i]);
            end
            if (v4) begin
                wr8(base + 9, PROTO_UDP);
                wr16(base + 10, ip_patch(rd16(base + 10), 16'(PROTO_TCP), 16'(PROTO_UDP)));
            end else begin
                wr8(base + 6, PROTO_UDP);
            end
            ck = l4_patch(rd16(t + 6), 32'(PROTO_TCP), 32'(PROTO_UDP));
            ck = l4_patch(ck, 32'h0, {16'h0, len});
            wr16(t + 6, ck);
            return PH_T2U;
        end
        if (proto == PROTO_UDP) begin
            if (t + 8 > avail) return PH_PASS;
            if (rd16(t + 4) < 8) return PH_PASS;
            if (seg_held) return PH_PASS;
            if (t + 20 > avail) return PH_PASS;
            for (int i = 0; i < 20; i++) c[i] = rd8(t + i);
            for (int i = 0; i < 4; i++) begin
                wr8(t + 4 + i, c[12 + i]);
                wr8(t + 8 + i, c[16 + i]);
                wr8(t + 12 + i, c[8 + i]);
            end
            wr8(t + 16, c[6]);
            wr8(t + 17, c[7]);
            wr16(t + 18, 16'h0);
            len = {c[4], c[5]};
            if (v4) begin
                wr8(base + 9, PROTO_TCP);
                wr16(base + 10, ip_patch(rd16(base + 10), 16'(PROTO_UDP), 16'(PROTO_TCP)));
            end else begin
                wr8(base + 6, PROTO_TCP);
            end
            ck = l4_patch(rd16(t + 16), 32'(PROTO_UDP), 32'(PROTO_TCP));
            ck = l4_patch(ck, {16'h0, len}, 32'h0);
            wr16(t + 16, ck);
            return PH_U2T;
        end
        return PH_PASS;
    endfunction

    function automatic void push_word(logic [63:0] w, logic [3:0] bv, logic last,
                                      t_phase ph);
        t_out_word e;
        e.word = w;
        e.bv = bv;
        e.last = last;
        e.kind = ph == PH_T2U ? KIND_T2U : (ph == PH_U2T ? KIND_U2T : KIND_NONE);
        e.verdict = ph == PH_T2U;
        expected_q.push_back(e);
    endfunction

    function automatic void take_word(logic [63:0] w, logic [3:0] bv_in, logic last,
                                      logic [15:0] tag, logic seg);
        logic [3:0] bv;
        t_phase     res;
        bv = bv_in > 8 ? 4'd8 : bv_in;
        if (phase != PH_COLLECT) begin
            push_word(w, bv, last, phase);
            if (last) phase = PH_COLLECT;
            return;
        end
        if (head_cnt == 0) begin
            tag_held = tag;
            seg_held = seg;
        end
        head_w[head_cnt] = w;
        head_bv[head_cnt] = bv;
        head_cnt++;
        if (!last && head_cnt < NWORDS) return;
        res = parse_head();
        for (int i = 0; i < head_cnt; i++)
            push_word(head_w[i], head_bv[i], last && i + 1 == head_cnt, res);
        head_cnt = 0;
        phase = last ? PH_COLLECT : res;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %h want %h", $time, what, got, want);
        o_fail_cnt++;
    endtask

    initial begin
        o_fail_cnt = 0;
        o_t2u_words = 0;
        o_u2t_words = 0;
        head_cnt = 0;
        phase = PH_COLLECT;
        tag_held = '0;
        seg_held = 0;
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && i_pkt.valid && i_pkt.ready)
            take_word(i_pkt.packet_word, i_pkt.bytes_valid, i_pkt.last_word,
                      i_pkt.l3_protocol, i_pkt.segmented);
        if (i_rst_n && i_res.valid && i_res.ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected item, word", i_res.out_word, 64'h0);
            end else begin
                e = expected_q.pop_front();
                if (i_res.out_word !== e.word) report("word", i_res.out_word, e.word);
                if (i_res.out_bytes_valid !== e.bv)
                    report("bytes_valid", 64'(i_res.out_bytes_valid), 64'(e.bv));
                if (i_res.out_last !== e.last)
                    report("last", 64'(i_res.out_last), 64'(e.last));
                if (i_res.rewrite_kind !== e.kind)
                    report("kind", 64'(i_res.rewrite_kind), 64'(e.kind));
                if (i_res.verdict !== e.verdict)
                    report("verdict", 64'(i_res.verdict), 64'(e.verdict));
                if (e.kind == KIND_T2U) o_t2u_words++;
                if (e.kind == KIND_U2T) o_u2t_words++;
            end
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top of the header swapper bench: clock, reset, packet stimulus and verdict.
// Depends on tusw_pkg, the channel interfaces, tusw_checker and the unit.
module testbench;
    import tusw_pkg::*;

    localparam int CYCLE_LIMIT = 900000;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt, pending, t2u_words, u2t_words;
    int   idle_in, stall_out, cycles, words_sent, pkts_sent;
    logic [7:0] pkt_q[$];
    logic [15:0] pkt_tag;
    logic        pkt_seg;

    tusw_in_if  pkt_if ();
    tusw_out_if res_if ();

    tcp_udp_header_swapper_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if),
        .o_res   (res_if)
    );

    tusw_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt       (pkt_if),
        .i_res       (res_if),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_t2u_words (t2u_words),
        .o_u2t_words (u2t_words)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        res_if.ready <= $urandom_range(99) >= stall_out;
    end

    // one item; acceptance is judged from ready at the falling edge
    task automatic send_word(logic [63:0] w, logic [3:0] bv, logic last,
                             logic [15:0] tag, logic seg);
        logic acc;
        while ($urandom_range(99) < idle_in) begin
            pkt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pkt_if.valid <= 1'b1;
        pkt_if.packet_word <= w;
        pkt_if.bytes_valid <= bv;
        pkt_if.last_word <= last;
        pkt_if.l3_protocol <= tag;
        pkt_if.segmented <= seg;
        do begin
            @(negedge i_clk);
            acc = pkt_if.ready;
            @(posedge i_clk);
        end while (!acc);
        words_sent++;
    endtask

    task automatic send_packet();
        int n, nw, bv;
        logic [63:0] w;
        n = pkt_q.size();
        nw = (n + 7) / 8;
        for (int i = 0; i < nw; i++) begin
            w = {$urandom, $urandom};
            bv = n - i * 8 > 8 ? 8 : n - i * 8;
            for (int b = 0; b < bv; b++) w[(7 - b) * 8 +: 8] = pkt_q[i * 8 + b];
            // tag and aggregate flag only count on the first word
            send_word(w, 4'(bv), i == nw - 1, i == 0 ? pkt_tag : 16'($urandom),
                      i == 0 ? pkt_seg : 1'($urandom));
        end
        pkts_sent++;
    endtask

    task automatic add_rand(int n);
        repeat (n) pkt_q.push_back(8'($urandom));
    endtask

    task automatic n_fix(int at, int v);
        pkt_q[at] = 8'(v >> 8);
        pkt_q[at + 1] = 8'(v);
    endtask

    // l3: 0 IPv4, 1 IPv6, 2 other; l4: 0 TCP, 1 UDP, 2 other
    task automatic build(bit eth, int l3, int l4, bit urg, bit bad, bit seg, int pay);
        int l3_at, ihl, doff, len_at;
        logic [15:0] et;
        et = l3 == 0 ? ET_IPV4 : (l3 == 1 ? ET_IPV6 : 16'($urandom));
        pkt_q.delete();
        pkt_seg = seg;
        pkt_tag = eth ? 16'($urandom) : et;
        if (eth) begin
            add_rand(12);
            pkt_q.push_back(et[15:8]);
            pkt_q.push_back(et[7:0]);
        end
        l3_at = pkt_q.size();
        ihl = 5;
        if (l3 == 1) begin
            add_rand(4);
            len_at = pkt_q.size();
            add_rand(2);
            pkt_q.push_back(l4 == 0 ? PROTO_TCP : (l4 == 1 ? PROTO_UDP : 8'd1));
            add_rand(33);
        end else begin
            ihl = bad && l4 == 2 ? $urandom_range(0, 4) : $urandom_range(5, 7);
            pkt_q.push_back({4'h4, 4'(ihl)});
            add_rand(1);
            len_at = pkt_q.size();
            add_rand(7);
            pkt_q.push_back(l4 == 0 ? PROTO_TCP : (l4 == 1 ? PROTO_UDP : 8'd1));
            add_rand(10);
            if (ihl > 5) add_rand((ihl - 5) * 4);
        end
        if (l4 == 0) begin
            doff = bad ? $urandom_range(0, 4) : $urandom_range(5, 8);
            add_rand(12);
            pkt_q.push_back({4'(doff), 4'($urandom)});
            pkt_q.push_back({2'($urandom), urg, 5'($urandom)});
            add_rand(6);
            if (doff > 5) add_rand((doff - 5) * 4);
        end else if (l4 == 1) begin
            add_rand(4);
            if (bad) begin
                pkt_q.push_back(8'h00);
                pkt_q.push_back(8'($urandom_range(0, 7)));
            end else begin
                add_rand(2);
            end
            add_rand(14);
        end
        add_rand(pay);
        // lengths mostly consistent, sometimes left random
        if ($urandom_range(3) != 0 && l3 != 2) begin
            n_fix(len_at, l3 == 1 ? pkt_q.size() - l3_at - 40 : pkt_q.size() - l3_at);
        end
        if ($urandom_range(9) == 0) pkt_q = pkt_q[0:$urandom_range(pkt_q.size() - 1)];
    endtask

    task automatic random_packet();
        int r, pay;
        r = $urandom_range(99);
        if (r < 8) begin
            // loose words: any bytes_valid, last only at the end
            pkt_tag = 16'($urandom);
            pkt_seg = 1'($urandom);
            repeat ($urandom_range(0, 20)) send_word({$urandom, $urandom}, 4'($urandom),
                                                    1'b0, 16'($urandom), 1'($urandom));
            send_word({$urandom, $urandom}, 4'($urandom), 1'b1, pkt_tag, pkt_seg);
            pkts_sent++;
            return;
        end
        pay = $urandom_range(11) == 0 ? $urandom_range(60, 130) : $urandom_range(0, 24);
        build($urandom_range(1), $urandom_range(9) == 0 ? 2 : $urandom_range(1),
              $urandom_range(9) == 0 ? 2 : $urandom_range(1), $urandom_range(4) == 0,
              $urandom_range(7) == 0, $urandom_range(9) == 0, pay);
        send_packet();
    endtask

    initial begin
        cycles = 0;
        words_sent = 0;
        pkts_sent = 0;
        idle_in = 0;
        stall_out = 0;
        i_rst_n = 1'b0;
        res_if.ready = 1'b0;
        pkt_if.valid = 1'b0;
        pkt_if.packet_word = '0;
        pkt_if.bytes_valid = '0;
        pkt_if.last_word = 1'b0;
        pkt_if.l3_protocol = '0;
        pkt_if.segmented = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme loose words, then one of each rewrite and an urgent one
        send_word('1, 4'hF, 1'b1, 16'hFFFF, 1'b1);
        send_word('0, 4'h0, 1'b1, 16'h0000, 1'b0);
        build(1, 0, 0, 0, 0, 0, 0);
        send_packet();
        build(0, 1, 1, 0, 0, 0, 0);
        send_packet();
        build(0, 0, 0, 1, 0, 0, 0);
        send_packet();

        for (int ph = 0; ph < 4; ph++) begin
            idle_in = ph == 1 || ph == 3 ? (ph == 3 ? 35 : 77) : 0;
            stall_out = ph == 2 ? 77 : (ph == 3 ? 35 : 0);
            if (ph == 2) begin
                // hold off until the unit has drained
                pkt_if.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            while (words_sent < 25 + (ph + 1) * 60) random_packet();
        end
        pkt_if.valid <= 1'b0;
        stall_out = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Sent %0d packets in %0d words; %0d words to UDP form, %0d back to TCP.",
                 pkts_sent, words_sent, t2u_words, u2t_words);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
